[rtl/core/rect_trim_against_rects_unit_assert.svh]
// assertion macros used by the rectangle trim unit
`ifndef RECT_TRIM_AGAINST_RECTS_UNIT_ASSERT_SVH
`define RECT_TRIM_AGAINST_RECTS_UNIT_ASSERT_SVH

// clocked assertion on a full property, quiet while reset is applied
`define RTAT_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// clocked assertion of a same-cycle implication
`define RTAT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/rtat_pkg.sv]
package rtat_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 16;
	// rectangle id and own id width
	localparam int ID_BITS = 8;
	// area compare keeps the low bits of the product only
	localparam int AREA_BITS = 32;

	// request opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TRIM  = 1'b1;

	// outcome of one trim test against the candidate
	typedef struct packed {
		logic miss;    // other rectangle does not touch the candidate
		logic take_h;  // horizontal trim chosen
		logic take_v;  // vertical trim chosen
		logic fail;    // touching, but neither trim is usable
	} trim_sel_t;

endpackage

[rtl/core/rect_trim_against_rects_unit.sv]
// Trims a candidate rectangle against a stream of other rectangles. A start
// request (op = 0) loads the candidate and clears the failure flag; each
// following request brings another rectangle that, unless its id matches the
// own id or it misses the candidate, cuts the candidate horizontally or
// vertically (larger area kept) or marks the set failed. A request with
// last = 1 yields one result with ok and the candidate. Throughput is one
// request per clock while in_ready is high: each request is registered into
// stage 1 and resolved there against the candidate, and one with last = 1
// then loads the result register that drives out_valid. The clock period is
// set by the candidate feedback loop: touch compares, extent subtracts, two
// 32-bit area products and their compare. in_ready falls only while a result
// waits at the output and a request with last = 1 is queued behind it.
module rect_trim_against_rects_unit #(
	parameter int COORD_BITS = rtat_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtat_pkg::ID_BITS-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [COORD_BITS-1:0]  left,
	input  logic signed [COORD_BITS-1:0]  top,
	input  logic signed [COORD_BITS-1:0]  right,
	input  logic signed [COORD_BITS-1:0]  bottom,
	input  logic [rtat_pkg::ID_BITS-1:0]  rect_id,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic signed [COORD_BITS-1:0]  out_left,
	output logic signed [COORD_BITS-1:0]  out_top,
	output logic signed [COORD_BITS-1:0]  out_right,
	output logic signed [COORD_BITS-1:0]  out_bottom
);
	import rtat_pkg::*;

	logic [ID_BITS-1:0]           own_id_q;
	logic                         valid_s1;
	logic                         op_s1;
	logic signed [COORD_BITS-1:0] left_s1;
	logic signed [COORD_BITS-1:0] top_s1;
	logic signed [COORD_BITS-1:0] right_s1;
	logic signed [COORD_BITS-1:0] bottom_s1;
	logic [ID_BITS-1:0]           id_s1;
	logic                         last_s1;
	logic signed [COORD_BITS-1:0] cur_left_q;
	logic signed [COORD_BITS-1:0] cur_top_q;
	logic signed [COORD_BITS-1:0] cur_right_q;
	logic signed [COORD_BITS-1:0] cur_bottom_q;
	logic                         failed_q;
	logic                         out_valid_q;
	logic                         ok_q;
	logic signed [COORD_BITS-1:0] out_left_q;
	logic signed [COORD_BITS-1:0] out_top_q;
	logic signed [COORD_BITS-1:0] out_right_q;
	logic signed [COORD_BITS-1:0] out_bottom_q;
	logic                         s1_adv;
	logic                         in_take;
	logic                         do_trim;
	logic signed [COORD_BITS-1:0] h_left;
	logic signed [COORD_BITS-1:0] h_right;
	logic signed [COORD_BITS-1:0] v_top;
	logic signed [COORD_BITS-1:0] v_bottom;
	trim_sel_t                    sel;
	logic signed [COORD_BITS-1:0] nxt_left;
	logic signed [COORD_BITS-1:0] nxt_top;
	logic signed [COORD_BITS-1:0] nxt_right;
	logic signed [COORD_BITS-1:0] nxt_bottom;
	logic                         nxt_failed;

	// own id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_we) begin
			own_id_q <= cfg_wdata;
		end
	end

	// stage 1 moves on unless its result would overwrite a waiting one
	assign s1_adv   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_take  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1     <= op;
			left_s1   <= left;
			top_s1    <= top;
			right_s1  <= right;
			bottom_s1 <= bottom;
			id_s1     <= rect_id;
			last_s1   <= last;
		end
	end

	// trim of the candidate against the registered rectangle
	rtat_trim_core #(
		.COORD_BITS (COORD_BITS)
	) u_trim (
		.cur_l    (cur_left_q),
		.cur_t    (cur_top_q),
		.cur_r    (cur_right_q),
		.cur_b    (cur_bottom_q),
		.oth_l    (left_s1),
		.oth_t    (top_s1),
		.oth_r    (right_s1),
		.oth_b    (bottom_s1),
		.h_left   (h_left),
		.h_right  (h_right),
		.v_top    (v_top),
		.v_bottom (v_bottom),
		.sel      (sel)
	);

	assign do_trim = (op_s1 == OP_TRIM) && !failed_q && (id_s1 != own_id_q);

	// next candidate and failure flag
	always_comb begin
		nxt_left   = cur_left_q;
		nxt_top    = cur_top_q;
		nxt_right  = cur_right_q;
		nxt_bottom = cur_bottom_q;
		nxt_failed = failed_q;
		if (op_s1 == OP_START) begin
			nxt_left   = left_s1;
			nxt_top    = top_s1;
			nxt_right  = right_s1;
			nxt_bottom = bottom_s1;
			nxt_failed = 1'b0;
		end else if (do_trim) begin
			if (sel.take_h) begin
				nxt_left  = h_left;
				nxt_right = h_right;
			end else if (sel.take_v) begin
				nxt_top    = v_top;
				nxt_bottom = v_bottom;
			end else if (sel.fail) begin
				nxt_failed = 1'b1;
			end
		end
	end

	// candidate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_left_q   <= '0;
			cur_top_q    <= '0;
			cur_right_q  <= '0;
			cur_bottom_q <= '0;
			failed_q     <= 1'b0;
		end else if (s1_adv) begin
			cur_left_q   <= nxt_left;
			cur_top_q    <= nxt_top;
			cur_right_q  <= nxt_right;
			cur_bottom_q <= nxt_bottom;
			failed_q     <= nxt_failed;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			ok_q         <= !nxt_failed;
			out_left_q   <= nxt_left;
			out_top_q    <= nxt_top;
			out_right_q  <= nxt_right;
			out_bottom_q <= nxt_bottom;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign out_left   = out_left_q;
	assign out_top    = out_top_q;
	assign out_right  = out_right_q;
	assign out_bottom = out_bottom_q;

	`include "rect_trim_against_rects_unit_assert.svh"

	// stall only comes from a held stage 1 request
	`RTAT_ASSERT_IMPL(a_stall_src, !in_ready, valid_s1 && last_s1 && out_valid_q,
		"input stalled without a blocked result")

	// a request without a result never waits
	`RTAT_ASSERT_IMPL(a_nolast_flows, valid_s1 && !last_s1, s1_adv,
		"request without result held in stage 1")

	// a finished last request shows up at the output
	`RTAT_ASSERT_CLK(a_result_out, s1_adv && last_s1 |=> out_valid,
		"result of a last request not presented")

	// start request clears the failure
	`RTAT_ASSERT_CLK(a_start_clear, s1_adv && (op_s1 == OP_START) |=> !failed_q,
		"start request did not clear failure")

	// failure freezes the candidate until the next start
	`RTAT_ASSERT_CLK(a_fail_sticky,
		failed_q && !(s1_adv && (op_s1 == OP_START)) |=>
			failed_q && $stable(cur_left_q) && $stable(cur_top_q) &&
			$stable(cur_right_q) && $stable(cur_bottom_q),
		"failed candidate changed before a start request")

endmodule

[rtl/core/rtat_trim_core.sv]
module rtat_trim_core #(
	parameter int COORD_BITS = rtat_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] cur_l,
	input  logic signed [COORD_BITS-1:0] cur_t,
	input  logic signed [COORD_BITS-1:0] cur_r,
	input  logic signed [COORD_BITS-1:0] cur_b,
	input  logic signed [COORD_BITS-1:0] oth_l,
	input  logic signed [COORD_BITS-1:0] oth_t,
	input  logic signed [COORD_BITS-1:0] oth_r,
	input  logic signed [COORD_BITS-1:0] oth_b,
	output logic signed [COORD_BITS-1:0] h_left,
	output logic signed [COORD_BITS-1:0] h_right,
	output logic signed [COORD_BITS-1:0] v_top,
	output logic signed [COORD_BITS-1:0] v_bottom,
	output rtat_pkg::trim_sel_t          sel
);
	import rtat_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int EW = (DW > AREA_BITS) ? DW : AREA_BITS;

	logic                 miss;
	logic                 aok;
	logic                 bok;
	logic                 h_bigger;
	logic signed [DW-1:0] wid_h;
	logic signed [DW-1:0] hgt_h;
	logic signed [DW-1:0] wid_v;
	logic signed [DW-1:0] hgt_v;
	logic signed [EW-1:0] wid_h_x;
	logic signed [EW-1:0] hgt_h_x;
	logic signed [EW-1:0] wid_v_x;
	logic signed [EW-1:0] hgt_v_x;
	logic [AREA_BITS-1:0] area_h;
	logic [AREA_BITS-1:0] area_v;

	// touch test, edges strictly beyond count as apart
	assign miss = (oth_l > cur_r) || (oth_r < cur_l) || (oth_t > cur_b) || (oth_b < cur_t);

	// candidate trims on each axis
	assign h_left   = (cur_l > oth_l) ? oth_r : cur_l;
	assign h_right  = (cur_l > oth_l) ? cur_r : oth_l;
	assign v_top    = (cur_t > oth_t) ? oth_b : cur_t;
	assign v_bottom = (cur_t > oth_t) ? cur_b : oth_t;

	// usable trims
	assign aok = (h_left < h_right) && ((oth_t < cur_b) || (oth_b < cur_t));
	assign bok = (v_top < v_bottom) && ((oth_l < cur_r) || (oth_r < cur_l));

	// extents, one bit wider than a coordinate
	assign wid_h = DW'(h_right) - DW'(h_left);
	assign hgt_h = DW'(cur_b) - DW'(cur_t);
	assign wid_v = DW'(cur_r) - DW'(cur_l);
	assign hgt_v = DW'(v_bottom) - DW'(v_top);

	// sign extend, then keep low product bits only
	assign wid_h_x = EW'(wid_h);
	assign hgt_h_x = EW'(hgt_h);
	assign wid_v_x = EW'(wid_v);
	assign hgt_v_x = EW'(hgt_v);

	assign area_h = wid_h_x[AREA_BITS-1:0] * hgt_h_x[AREA_BITS-1:0];
	assign area_v = wid_v_x[AREA_BITS-1:0] * hgt_v_x[AREA_BITS-1:0];

	// unsigned compare, vertical wins a tie
	assign h_bigger = area_h > area_v;

	// selection
	always_comb begin
		sel.miss   = miss;
		sel.take_h = !miss && aok && (!bok || h_bigger);
		sel.take_v = !miss && bok && !(aok && h_bigger);
		sel.fail   = !miss && !aok && !bok;
	end

endmodule
